// ===== sv/hsd_pkg.sv =====
// Shared types and constants for the horizon search block.
// Holds the command queued between the front and back ends and the
// configuration limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

	localparam int MAP_SIZE_DEF = 256;
	localparam int FIFO_DEPTH = 2;
	localparam int QUOT_W = 24;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] TILE_RESET = 3'd2;
	localparam logic [2:0] TILE_MIN = 3'd1;
	localparam logic [2:0] TILE_MAX = 3'd4;

	typedef struct packed {
		logic        is_query;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [7:0]  cell_height;
		logic [8:0]  query_x;
		logic [8:0]  query_y;
		logic [7:0]  query_z;
		logic        x_major;
		logic        neg_maj;
		logic        neg_min;
		logic [9:0]  amaj;
		logic [9:0]  amin;
		logic [2:0]  tiles;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/hsd_if.sv =====
// Channel interfaces of the horizon search block: request and response.
// Each carries valid, ready and the beat payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hsd_in_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [7:0]        cell_x;
	logic [7:0]        cell_y;
	logic [7:0]        cell_height;
	logic [8:0]        query_x;
	logic [8:0]        query_y;
	logic [7:0]        query_z;
	logic signed [9:0] dir_x;
	logic signed [9:0] dir_y;

	modport source (output valid, opcode, cell_x, cell_y, cell_height, query_x, query_y,
		query_z, dir_x, dir_y, input ready);
	modport sink (input valid, opcode, cell_x, cell_y, cell_height, query_x, query_y,
		query_z, dir_x, dir_y, output ready);
endinterface

interface hsd_out_if;
	logic               valid;
	logic               ready;
	logic [18:0]        distance_q8;
	logic signed [24:0] elevation_q16;
	logic signed [11:0] horizon_x;
	logic signed [11:0] horizon_y;
	logic [7:0]         horizon_z;

	modport source (output valid, distance_q8, elevation_q16, horizon_x, horizon_y,
		horizon_z, input ready);
	modport sink (input valid, distance_q8, elevation_q16, horizon_x, horizon_y,
		horizon_z, output ready);
endinterface

`default_nettype wire

// ===== sv/hsd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/hsd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on hsd_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module hsd_fifo import hsd_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	output logic      nonempty,
	output cmd_t      head,
	input  wire logic pop
);

	localparam int PW = $clog2(DEPTH);

	cmd_t            slot_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hsd_front.sv =====
// Front end: accepts request beats and classifies them into queue commands.
// Queries get their line setup here. Depends on hsd_pkg and hsd_if.
`timescale 1ns / 1ps
`default_nettype none

module hsd_front import hsd_pkg::*; (
	hsd_in_if.sink          req,
	input  wire logic [2:0] tile_count,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            cmd
);

	logic [9:0] neg_dx;
	logic [9:0] neg_dy;
	logic [9:0] adx;
	logic [9:0] ady;
	logic       xm;

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	always_comb begin
		neg_dx = -req.dir_x;
		neg_dy = -req.dir_y;
		adx = req.dir_x[9] ? neg_dx : req.dir_x;
		ady = req.dir_y[9] ? neg_dy : req.dir_y;
		xm = (ady < adx);

		cmd.is_query = (req.opcode == OP_QUERY);
		cmd.cell_x = req.cell_x;
		cmd.cell_y = req.cell_y;
		cmd.cell_height = req.cell_height;
		cmd.query_x = req.query_x;
		cmd.query_y = req.query_y;
		cmd.query_z = req.query_z;
		cmd.x_major = xm;
		cmd.neg_maj = xm ? req.dir_x[9] : req.dir_y[9];
		cmd.neg_min = xm ? req.dir_y[9] : req.dir_x[9];
		cmd.amaj = xm ? adx : ady;
		cmd.amin = xm ? ady : adx;
		if (tile_count < TILE_MIN) begin
			cmd.tiles = TILE_MIN;
		end else if (tile_count > TILE_MAX) begin
			cmd.tiles = TILE_MAX;
		end else begin
			cmd.tiles = tile_count;
		end
	end

endmodule

`default_nettype wire

// ===== sv/hsd_back.sv =====
// Back end: runs heightmap writes and the horizon line walk per query.
// Each sample uses a shared bit-serial square root and divider.
// Depends on hsd_pkg and hsd_if; drives the heightmap RAM ports.
`timescale 1ns / 1ps
`default_nettype none

module hsd_back import hsd_pkg::*; #(
	parameter int MAP_SIZE = MAP_SIZE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_nonempty,
	input  wire cmd_t                           q_head,
	output logic                                q_pop,
	output logic                                ram_we,
	output logic [2*$clog2(MAP_SIZE)-1:0]       ram_waddr,
	output logic [7:0]                          ram_wdata,
	output logic                                ram_re,
	output logic [2*$clog2(MAP_SIZE)-1:0]       ram_raddr,
	input  wire logic [7:0]                     ram_rdata,
	hsd_out_if.source                           rsp
);

	localparam int AW = $clog2(MAP_SIZE);
	localparam int MaxSamples = 4 * MAP_SIZE;
	localparam int KW = $clog2(MaxSamples) + 1;
	localparam int DW = KW + 8;
	localparam int NW = 2 * KW + 16;
	localparam int RW = DW + 2;
	localparam int CW = $clog2(MaxSamples + 512) + 1;
	localparam int IW = $clog2(DW + QUOT_W);

	typedef enum logic [2:0] {
		ST_IDLE, ST_STEP, ST_MUL, ST_SQINIT, ST_SQRT, ST_DIV, ST_CMP, ST_DONE
	} state_t;

	state_t             state_q;
	logic               x_major_q;
	logic               neg_maj_q;
	logic               neg_min_q;
	logic [9:0]         amaj_q;
	logic [9:0]         amin_q;
	logic [7:0]         z0_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [12:0] acc_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      j_q;
	logic [KW-1:0]      left_q;
	logic [2*KW-1:0]    sqk_s1;
	logic [2*KW-1:0]    sqj_s1;
	logic [7:0]         z_q;
	logic [NW-1:0]      n_q;
	logic [RW-1:0]      srem_q;
	logic [DW-1:0]      root_q;
	logic [DW:0]        drem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [IW-1:0]      iter_q;
	logic               have_q;
	logic signed [24:0] best_e_q;
	logic [DW-1:0]      best_d_q;
	logic signed [CW-1:0] best_x_q;
	logic signed [CW-1:0] best_y_q;
	logic [7:0]         best_z_q;
	logic               out_valid_q;
	logic [18:0]        out_d_q;
	logic signed [24:0] out_e_q;
	logic signed [11:0] out_x_q;
	logic signed [11:0] out_y_q;
	logic [7:0]         out_z_q;

	logic signed [12:0]   acc_add;
	logic                 minor_move;
	logic signed [CW-1:0] step_maj;
	logic signed [CW-1:0] step_min;
	logic [2*KW-1:0]      d2;
	logic [RW-1:0]        srem_sh;
	logic [RW-1:0]        trial;
	logic [DW:0]          drem_sh;
	logic signed [8:0]    dz;
	logic [8:0]           dz_neg;
	logic [7:0]           adz;
	logic signed [24:0]   qext;
	logic signed [24:0]   e_cur;
	logic [31:0]          bd32;
	logic                 out_free;

	assign rsp.valid = out_valid_q;
	assign rsp.distance_q8 = out_d_q;
	assign rsp.elevation_q16 = out_e_q;
	assign rsp.horizon_x = out_x_q;
	assign rsp.horizon_y = out_y_q;
	assign rsp.horizon_z = out_z_q;

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_nonempty;
		ram_we = q_pop && !q_head.is_query;
		ram_waddr = {AW'(q_head.cell_y), AW'(q_head.cell_x)};
		ram_wdata = q_head.cell_height;
		ram_re = (state_q == ST_MUL);
		ram_raddr = {y_q[AW-1:0], x_q[AW-1:0]};

		acc_add = acc_q + $signed({2'b00, amin_q, 1'b0});
		minor_move = (acc_add > $signed({3'b000, amaj_q}));
		step_maj = neg_maj_q ? CW'(-1) : CW'(1);
		step_min = minor_move ? step_maj : '0;
		if (minor_move) begin
			step_min = neg_min_q ? CW'(-1) : CW'(1);
		end

		d2 = (2*KW)'(sqk_s1 + sqj_s1);
		srem_sh = {srem_q[RW-3:0], n_q[NW-1:NW-2]};
		trial = {root_q, 2'b01};
		drem_sh = {drem_q[DW-1:0], 1'b0};

		dz = $signed({1'b0, z_q}) - $signed({1'b0, z0_q});
		dz_neg = -dz;
		adz = dz[8] ? dz_neg[7:0] : dz[7:0];
		qext = $signed({1'b0, quot_q});
		e_cur = dz[8] ? -qext : qext;
		bd32 = 32'(best_d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_nonempty && q_head.is_query) begin
						x_major_q <= q_head.x_major;
						neg_maj_q <= q_head.neg_maj;
						neg_min_q <= q_head.neg_min;
						amaj_q <= q_head.amaj;
						amin_q <= q_head.amin;
						z0_q <= q_head.query_z;
						x_q <= CW'({1'b0, q_head.query_x});
						y_q <= CW'({1'b0, q_head.query_y});
						acc_q <= '0;
						k_q <= '0;
						j_q <= '0;
						left_q <= KW'(q_head.tiles) << AW;
						have_q <= 1'b0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					x_q <= x_q + (x_major_q ? step_maj : step_min);
					y_q <= y_q + (x_major_q ? step_min : step_maj);
					acc_q <= minor_move ? acc_add - $signed({2'b00, amaj_q, 1'b0}) : acc_add;
					k_q <= k_q + 1'b1;
					if (minor_move) begin
						j_q <= j_q + 1'b1;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					sqk_s1 <= k_q * k_q;
					sqj_s1 <= j_q * j_q;
					state_q <= ST_SQINIT;
				end
				ST_SQINIT: begin
					z_q <= ram_rdata;
					n_q <= {d2, 16'h0000};
					srem_q <= '0;
					root_q <= '0;
					iter_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					n_q <= {n_q[NW-3:0], 2'b00};
					if (srem_sh >= trial) begin
						srem_q <= srem_sh - trial;
						root_q <= {root_q[DW-2:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[DW-2:0], 1'b0};
					end
					if (iter_q == IW'(DW - 1)) begin
						drem_q <= (DW+1)'(adz);
						quot_q <= '0;
						iter_q <= '0;
						state_q <= ST_DIV;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (drem_sh >= {1'b0, root_q}) begin
						drem_q <= drem_sh - {1'b0, root_q};
						quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == IW'(QUOT_W - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!have_q || e_cur > best_e_q) begin
						have_q <= 1'b1;
						best_e_q <= e_cur;
						best_d_q <= root_q;
						best_x_q <= x_q;
						best_y_q <= y_q;
						best_z_q <= z_q;
					end
					left_q <= left_q - 1'b1;
					state_q <= (left_q == KW'(1)) ? ST_DONE : ST_STEP;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_d_q <= (bd32 > 32'd524287) ? 19'h7FFFF : bd32[18:0];
						out_e_q <= best_e_q;
						out_x_q <= 12'(best_x_q);
						out_y_q <= 12'(best_y_q);
						out_z_q <= best_z_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/horizon_search_dda.sv =====
// Horizon search over a wrapping square heightmap by a Bresenham line walk.
// Top level: configuration register, front end, command queue, back end and
// heightmap RAM. Depends on hsd_pkg, hsd_if, hsd_ram, hsd_fifo, hsd_front, hsd_back.
//
// The request channel req carries one beat per item: opcode 0 writes one height
// byte into the map, opcode 1 runs a horizon query. The response channel rsp
// returns one beat per query, none per write; cfg_we and cfg_wdata write tile_count,
// which the user must do only while the block is idle (not enforced); it resets to 2.
// The front end takes a beat in every cycle while the two-entry command queue
// has room. The back end handles one item at a time: it performs a write directly
// from idle, and for a query it walks tile_count * MAP_SIZE samples, each through
// step, multiply, square-root setup, the serial square root, the serial divider
// and the compare. After the compare of the last sample it enters its done state
// and loads the result register there once the output register is free.
// The result waits in an output register; while the receiver stalls the back
// end keeps working on later items and halts only when a second result is ready.
// Reset empties the queue and drops any pending result; the heightmap is not
// cleared, and cells must be written before a query reads them.
`timescale 1ns / 1ps
`default_nettype none

module horizon_search_dda import hsd_pkg::*; #(
	parameter int MAP_SIZE = MAP_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	hsd_in_if.sink          req,
	hsd_out_if.source       rsp
);

	localparam int AW = $clog2(MAP_SIZE);

	logic [2:0]      tile_q;
	logic            q_full;
	logic            q_nonempty;
	logic            push;
	logic            pop;
	cmd_t            cmd;
	cmd_t            head;
	logic            ram_we;
	logic [2*AW-1:0] ram_waddr;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [2*AW-1:0] ram_raddr;
	logic [7:0]      ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= TILE_RESET;
		end else if (cfg_we) begin
			tile_q <= cfg_wdata;
		end
	end

	hsd_front u_front (
		.req        (req),
		.tile_count (tile_q),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd)
	);

	hsd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (head),
		.pop       (pop)
	);

	hsd_back #(.MAP_SIZE(MAP_SIZE)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head),
		.q_pop      (pop),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rsp        (rsp)
	);

	hsd_ram #(.WIDTH(8), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire
